FILE: rtl/core/blu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Byte load unit package
// Types, codes and decode helpers shared by the front end, the word queue and
// the execute stage of the byte load instruction unit.
// ----------------------------------------------------------------------------
package blu_pkg;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [15:0] HIGH_PAGE = 16'hff00;

  typedef logic [2:0] reg_idx_t;

  localparam reg_idx_t IDX_B = 3'd0;
  localparam reg_idx_t IDX_C = 3'd1;
  localparam reg_idx_t IDX_D = 3'd2;
  localparam reg_idx_t IDX_E = 3'd3;
  localparam reg_idx_t IDX_H = 3'd4;
  localparam reg_idx_t IDX_L = 3'd5;
  localparam reg_idx_t IDX_A = 3'd6;

  localparam logic [2:0] CODE_MEM_HL = 3'd6;
  localparam logic [2:0] CODE_A      = 3'd7;

  localparam logic [7:0] OP_LD_GROUP_LO = 8'h40;
  localparam logic [7:0] OP_LD_GROUP_HI = 8'h7f;
  localparam logic [7:0] OP_HALT        = 8'h76;
  localparam logic [7:0] OP_LD_IMM_MASK = 8'hc7;
  localparam logic [7:0] OP_LD_IMM_BITS = 8'h06;
  localparam logic [7:0] OP_LD_BC_A     = 8'h02;
  localparam logic [7:0] OP_LD_DE_A     = 8'h12;
  localparam logic [7:0] OP_LD_A_BC     = 8'h0a;
  localparam logic [7:0] OP_LD_A_DE     = 8'h1a;
  localparam logic [7:0] OP_LD_HLI_A    = 8'h22;
  localparam logic [7:0] OP_LD_HLD_A    = 8'h32;
  localparam logic [7:0] OP_LD_A_HLI    = 8'h2a;
  localparam logic [7:0] OP_LD_A_HLD    = 8'h3a;
  localparam logic [7:0] OP_LDH_N_A     = 8'he0;
  localparam logic [7:0] OP_LDH_A_N     = 8'hf0;
  localparam logic [7:0] OP_LDH_C_A     = 8'he2;
  localparam logic [7:0] OP_LDH_A_C     = 8'hf2;
  localparam logic [7:0] OP_LD_NN_A     = 8'hea;
  localparam logic [7:0] OP_LD_A_NN     = 8'hfa;

  localparam logic CMD_EXECUTE     = 1'b0;
  localparam logic CMD_READ_RETURN = 1'b1;

  typedef enum logic [1:0] {
    BUS_NONE = 2'd0,
    BUS_RD   = 2'd1,
    BUS_WR   = 2'd2
  } bus_op_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_WAIT      = 2'd1,
    ST_UNSUP     = 2'd2,
    ST_OUT_ORDER = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    K_READ_RETURN,
    K_MOVE,
    K_LOAD_IMM,
    K_STORE,
    K_LOAD_MEM,
    K_UNSUPPORTED
  } kind_t;

  typedef enum logic [2:0] {
    ADDR_HL,
    ADDR_BC,
    ADDR_DE,
    ADDR_HIGH_IMM,
    ADDR_HIGH_C,
    ADDR_ABS
  } addr_sel_t;

  typedef enum logic [1:0] {
    HL_KEEP,
    HL_INC,
    HL_DEC
  } hl_adj_t;

  typedef struct packed {
    kind_t       kind;
    addr_sel_t   addr_sel;
    hl_adj_t     hl_adj;
    logic        use_imm;
    reg_idx_t    src;
    reg_idx_t    dst;
    logic [15:0] immediate;
    logic [7:0]  read_data;
  } word_t;

  function automatic reg_idx_t code_to_index(input logic [2:0] code);
    reg_idx_t idx;
    idx = (code == CODE_A) ? IDX_A : code;
    return idx;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/byte_load_instruction_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Byte load instruction unit
// Executes the 8-bit load group: register moves, immediate loads, stores and
// read requests, completing each read when its data word returns.
//
//   Channel  Handshake               Payload
//   in       in_valid / in_ready     cmd, opcode, immediate, read_data
//   out      out_valid / out_ready   bus_op, bus_addr, bus_wdata, status,
//                                    value_a .. value_l
//
// One word per cycle is sustained while out_ready stays high. A word accepted
// by the front end is written into the decode queue, is executed from the
// queue head into the output register and is held there until it is taken.
// The two-entry queue lets the front end accept two more words while the
// output register is stalled; in_ready then stays low until a result is
// taken. Reset clears the registers, the pending read and the queue.
// ----------------------------------------------------------------------------
module byte_load_instruction_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        cmd,
  input  wire logic [7:0]  opcode,
  input  wire logic [15:0] immediate,
  input  wire logic [7:0]  read_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       bus_op,
  output logic [15:0]      bus_addr,
  output logic [7:0]       bus_wdata,
  output logic [1:0]       status,
  output logic [7:0]       value_a,
  output logic [7:0]       value_b,
  output logic [7:0]       value_c,
  output logic [7:0]       value_d,
  output logic [7:0]       value_e,
  output logic [7:0]       value_h,
  output logic [7:0]       value_l
);

  logic           push;
  blu_pkg::word_t push_word;
  logic           queue_full;
  logic           head_valid;
  blu_pkg::word_t head_word;
  logic           pop;

  blu_front u_front (
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .cmd        (cmd),
    .opcode     (opcode),
    .immediate  (immediate),
    .read_data  (read_data),
    .push       (push),
    .push_word  (push_word),
    .queue_full (queue_full)
  );

  blu_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_word  (push_word),
    .full       (queue_full),
    .head_valid (head_valid),
    .head_word  (head_word),
    .pop        (pop)
  );

  blu_execute u_execute (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_word  (head_word),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .bus_op     (bus_op),
    .bus_addr   (bus_addr),
    .bus_wdata  (bus_wdata),
    .status     (status),
    .value_a    (value_a),
    .value_b    (value_b),
    .value_c    (value_c),
    .value_d    (value_d),
    .value_e    (value_e),
    .value_h    (value_h),
    .value_l    (value_l)
  );

endmodule
`default_nettype wire

FILE: rtl/core/blu_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Byte load unit front end
// Accepts input words and classifies each opcode into a decoded word for the
// queue towards the execute stage.
// ----------------------------------------------------------------------------
module blu_front (
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire logic           cmd,
  input  wire logic [7:0]     opcode,
  input  wire logic [15:0]    immediate,
  input  wire logic [7:0]     read_data,
  output logic                push,
  output blu_pkg::word_t      push_word,
  input  wire logic           queue_full
);

  logic [2:0] dst_code;
  logic [2:0] src_code;

  assign in_ready = !queue_full;
  assign push     = in_valid && !queue_full;
  assign dst_code = opcode[5:3];
  assign src_code = opcode[2:0];

  always_comb begin
    push_word           = '0;
    push_word.kind      = blu_pkg::K_UNSUPPORTED;
    push_word.addr_sel  = blu_pkg::ADDR_HL;
    push_word.hl_adj    = blu_pkg::HL_KEEP;
    push_word.use_imm   = 1'b0;
    push_word.src       = blu_pkg::IDX_A;
    push_word.dst       = blu_pkg::IDX_A;
    push_word.immediate = immediate;
    push_word.read_data = read_data;
    if (cmd == blu_pkg::CMD_READ_RETURN) begin
      push_word.kind = blu_pkg::K_READ_RETURN;
    end else if ((opcode inside {[blu_pkg::OP_LD_GROUP_LO:blu_pkg::OP_LD_GROUP_HI]})
                 && opcode != blu_pkg::OP_HALT) begin
      if (src_code == blu_pkg::CODE_MEM_HL) begin
        push_word.kind = blu_pkg::K_LOAD_MEM;
        push_word.dst  = blu_pkg::code_to_index(dst_code);
      end else if (dst_code == blu_pkg::CODE_MEM_HL) begin
        push_word.kind = blu_pkg::K_STORE;
        push_word.src  = blu_pkg::code_to_index(src_code);
      end else begin
        push_word.kind = blu_pkg::K_MOVE;
        push_word.src  = blu_pkg::code_to_index(src_code);
        push_word.dst  = blu_pkg::code_to_index(dst_code);
      end
    end else if ((opcode & blu_pkg::OP_LD_IMM_MASK) == blu_pkg::OP_LD_IMM_BITS) begin
      if (dst_code == blu_pkg::CODE_MEM_HL) begin
        push_word.kind    = blu_pkg::K_STORE;
        push_word.use_imm = 1'b1;
      end else begin
        push_word.kind = blu_pkg::K_LOAD_IMM;
        push_word.dst  = blu_pkg::code_to_index(dst_code);
      end
    end else begin
      case (opcode)
        blu_pkg::OP_LD_BC_A: begin
          push_word.kind     = blu_pkg::K_STORE;
          push_word.addr_sel = blu_pkg::ADDR_BC;
        end
        blu_pkg::OP_LD_DE_A: begin
          push_word.kind     = blu_pkg::K_STORE;
          push_word.addr_sel = blu_pkg::ADDR_DE;
        end
        blu_pkg::OP_LD_A_BC: begin
          push_word.kind     = blu_pkg::K_LOAD_MEM;
          push_word.addr_sel = blu_pkg::ADDR_BC;
        end
        blu_pkg::OP_LD_A_DE: begin
          push_word.kind     = blu_pkg::K_LOAD_MEM;
          push_word.addr_sel = blu_pkg::ADDR_DE;
        end
        blu_pkg::OP_LD_HLI_A: begin
          push_word.kind   = blu_pkg::K_STORE;
          push_word.hl_adj = blu_pkg::HL_INC;
        end
        blu_pkg::OP_LD_HLD_A: begin
          push_word.kind   = blu_pkg::K_STORE;
          push_word.hl_adj = blu_pkg::HL_DEC;
        end
        blu_pkg::OP_LD_A_HLI: begin
          push_word.kind   = blu_pkg::K_LOAD_MEM;
          push_word.hl_adj = blu_pkg::HL_INC;
        end
        blu_pkg::OP_LD_A_HLD: begin
          push_word.kind   = blu_pkg::K_LOAD_MEM;
          push_word.hl_adj = blu_pkg::HL_DEC;
        end
        blu_pkg::OP_LDH_N_A: begin
          push_word.kind     = blu_pkg::K_STORE;
          push_word.addr_sel = blu_pkg::ADDR_HIGH_IMM;
        end
        blu_pkg::OP_LDH_A_N: begin
          push_word.kind     = blu_pkg::K_LOAD_MEM;
          push_word.addr_sel = blu_pkg::ADDR_HIGH_IMM;
        end
        blu_pkg::OP_LDH_C_A: begin
          push_word.kind     = blu_pkg::K_STORE;
          push_word.addr_sel = blu_pkg::ADDR_HIGH_C;
        end
        blu_pkg::OP_LDH_A_C: begin
          push_word.kind     = blu_pkg::K_LOAD_MEM;
          push_word.addr_sel = blu_pkg::ADDR_HIGH_C;
        end
        blu_pkg::OP_LD_NN_A: begin
          push_word.kind     = blu_pkg::K_STORE;
          push_word.addr_sel = blu_pkg::ADDR_ABS;
        end
        blu_pkg::OP_LD_A_NN: begin
          push_word.kind     = blu_pkg::K_LOAD_MEM;
          push_word.addr_sel = blu_pkg::ADDR_ABS;
        end
        default: begin
          push_word.kind = blu_pkg::K_UNSUPPORTED;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/blu_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Byte load unit word queue
// Short first-in first-out queue of decoded words between the front end and
// the execute stage.
// ----------------------------------------------------------------------------
module blu_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire blu_pkg::word_t push_word,
  output logic                full,
  output logic                head_valid,
  output blu_pkg::word_t      head_word,
  input  wire logic           pop
);

  blu_pkg::word_t                      entries [blu_pkg::QUEUE_DEPTH];
  logic [blu_pkg::QUEUE_PTR_W-1:0]     wr_ptr;
  logic [blu_pkg::QUEUE_PTR_W-1:0]     rd_ptr;
  logic [blu_pkg::QUEUE_CNT_W-1:0]     count;
  logic                                do_push;
  logic                                do_pop;

  assign full       = (count == blu_pkg::QUEUE_CNT_W'(blu_pkg::QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_word  = entries[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == blu_pkg::QUEUE_PTR_W'(blu_pkg::QUEUE_DEPTH - 1))
                  ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == blu_pkg::QUEUE_PTR_W'(blu_pkg::QUEUE_DEPTH - 1))
                  ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/blu_execute.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Byte load unit execute stage
// Holds the register file and the pending read, carries out one decoded word
// per cycle unless the output stalls, and registers bus request and status.
// ----------------------------------------------------------------------------
module blu_execute (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           head_valid,
  input  wire blu_pkg::word_t head_word,
  output logic                pop,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic [1:0]          bus_op,
  output logic [15:0]         bus_addr,
  output logic [7:0]          bus_wdata,
  output logic [1:0]          status,
  output logic [7:0]          value_a,
  output logic [7:0]          value_b,
  output logic [7:0]          value_c,
  output logic [7:0]          value_d,
  output logic [7:0]          value_e,
  output logic [7:0]          value_h,
  output logic [7:0]          value_l
);

  logic [7:0] reg_a, reg_b, reg_c, reg_d, reg_e, reg_h, reg_l;
  logic [7:0] reg_a_next, reg_b_next, reg_c_next, reg_d_next;
  logic [7:0] reg_e_next, reg_h_next, reg_l_next;
  logic       read_pending, read_pending_next;
  blu_pkg::reg_idx_t pending_target, pending_target_next;

  blu_pkg::bus_op_t bus_op_next;
  blu_pkg::status_t status_next;
  logic [15:0]      bus_addr_next;
  logic [7:0]       bus_wdata_next;

  logic [15:0] hl;
  logic [15:0] hl_adj;
  logic [15:0] sel_addr;
  logic [7:0]  src_value;
  logic        write_en;
  blu_pkg::reg_idx_t write_idx;
  logic [7:0]  write_value;
  logic        fire;

  assign fire = head_valid && (!out_valid || out_ready);
  assign pop  = fire;
  assign hl   = {reg_h, reg_l};

  always_comb begin
    case (head_word.src)
      blu_pkg::IDX_B: src_value = reg_b;
      blu_pkg::IDX_C: src_value = reg_c;
      blu_pkg::IDX_D: src_value = reg_d;
      blu_pkg::IDX_E: src_value = reg_e;
      blu_pkg::IDX_H: src_value = reg_h;
      blu_pkg::IDX_L: src_value = reg_l;
      default:        src_value = reg_a;
    endcase
  end

  always_comb begin
    case (head_word.addr_sel)
      blu_pkg::ADDR_BC:       sel_addr = {reg_b, reg_c};
      blu_pkg::ADDR_DE:       sel_addr = {reg_d, reg_e};
      blu_pkg::ADDR_HIGH_IMM: sel_addr = blu_pkg::HIGH_PAGE | {8'h00, head_word.immediate[7:0]};
      blu_pkg::ADDR_HIGH_C:   sel_addr = blu_pkg::HIGH_PAGE | {8'h00, reg_c};
      blu_pkg::ADDR_ABS:      sel_addr = head_word.immediate;
      default:                sel_addr = hl;
    endcase
  end

  always_comb begin
    case (head_word.hl_adj)
      blu_pkg::HL_INC: hl_adj = hl + 16'd1;
      blu_pkg::HL_DEC: hl_adj = hl - 16'd1;
      default:         hl_adj = hl;
    endcase
  end

  always_comb begin
    bus_op_next         = blu_pkg::BUS_NONE;
    bus_addr_next       = '0;
    bus_wdata_next      = '0;
    status_next         = blu_pkg::ST_DONE;
    read_pending_next   = read_pending;
    pending_target_next = pending_target;
    write_en            = 1'b0;
    write_idx           = head_word.dst;
    write_value         = src_value;
    reg_h_next          = reg_h;
    reg_l_next          = reg_l;

    if (head_word.kind == blu_pkg::K_READ_RETURN) begin
      if (read_pending) begin
        write_en          = 1'b1;
        write_idx         = pending_target;
        write_value       = head_word.read_data;
        read_pending_next = 1'b0;
      end else begin
        status_next = blu_pkg::ST_OUT_ORDER;
      end
    end else if (read_pending) begin
      status_next = blu_pkg::ST_OUT_ORDER;
    end else begin
      case (head_word.kind)
        blu_pkg::K_MOVE: begin
          write_en = 1'b1;
        end
        blu_pkg::K_LOAD_IMM: begin
          write_en    = 1'b1;
          write_value = head_word.immediate[7:0];
        end
        blu_pkg::K_STORE: begin
          bus_op_next    = blu_pkg::BUS_WR;
          bus_addr_next  = sel_addr;
          bus_wdata_next = head_word.use_imm ? head_word.immediate[7:0] : src_value;
          reg_h_next     = hl_adj[15:8];
          reg_l_next     = hl_adj[7:0];
        end
        blu_pkg::K_LOAD_MEM: begin
          bus_op_next         = blu_pkg::BUS_RD;
          bus_addr_next       = sel_addr;
          status_next         = blu_pkg::ST_WAIT;
          read_pending_next   = 1'b1;
          pending_target_next = head_word.dst;
          reg_h_next          = hl_adj[15:8];
          reg_l_next          = hl_adj[7:0];
        end
        default: begin
          status_next = blu_pkg::ST_UNSUP;
        end
      endcase
    end

    reg_a_next = reg_a;
    reg_b_next = reg_b;
    reg_c_next = reg_c;
    reg_d_next = reg_d;
    reg_e_next = reg_e;
    if (write_en) begin
      case (write_idx)
        blu_pkg::IDX_B: reg_b_next = write_value;
        blu_pkg::IDX_C: reg_c_next = write_value;
        blu_pkg::IDX_D: reg_d_next = write_value;
        blu_pkg::IDX_E: reg_e_next = write_value;
        blu_pkg::IDX_H: reg_h_next = write_value;
        blu_pkg::IDX_L: reg_l_next = write_value;
        blu_pkg::IDX_A: reg_a_next = write_value;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_a          <= '0;
      reg_b          <= '0;
      reg_c          <= '0;
      reg_d          <= '0;
      reg_e          <= '0;
      reg_h          <= '0;
      reg_l          <= '0;
      read_pending   <= 1'b0;
      pending_target <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (fire) begin
        reg_a          <= reg_a_next;
        reg_b          <= reg_b_next;
        reg_c          <= reg_c_next;
        reg_d          <= reg_d_next;
        reg_e          <= reg_e_next;
        reg_h          <= reg_h_next;
        reg_l          <= reg_l_next;
        read_pending   <= read_pending_next;
        pending_target <= pending_target_next;
        out_valid      <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      bus_op    <= bus_op_next;
      bus_addr  <= bus_addr_next;
      bus_wdata <= bus_wdata_next;
      status    <= status_next;
    end
  end

  assign value_a = reg_a;
  assign value_b = reg_b;
  assign value_c = reg_c;
  assign value_d = reg_d;
  assign value_e = reg_e;
  assign value_h = reg_h;
  assign value_l = reg_l;

endmodule
`default_nettype wire

FILE: sim/tb_byte_load_instruction_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Byte load instruction unit testbench
// Drives instruction and read-return words into the unit with random idle
// gaps on both channels. A scoreboard keeps its own copy of the register
// file and the outstanding read, predicts the bus request, status and
// registers for every accepted word, and checks each result in order.
// ----------------------------------------------------------------------------
module tb_byte_load_instruction_unit;

  localparam int CLK_PERIOD   = 10;
  localparam int RANDOM_WORDS = 850;
  localparam int HOLD_CYCLES  = 80;
  localparam int STALL_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 4;

  localparam logic [7:0] OP_LD_A_N  = 8'h3e;
  localparam logic [7:0] OP_LD_B_N  = 8'h06;
  localparam logic [7:0] OP_LD_C_N  = 8'h0e;
  localparam logic [7:0] OP_LD_H_N  = 8'h26;
  localparam logic [7:0] OP_LD_L_N  = 8'h2e;
  localparam logic [7:0] OP_LD_HL_N = 8'h36;
  localparam logic [7:0] OP_LD_A_B  = 8'h78;
  localparam logic [7:0] OP_LD_HL_B = 8'h70;
  localparam logic [7:0] OP_LD_A_HL = 8'h7e;
  localparam logic [7:0] OP_UNDEF   = 8'hff;

  typedef struct {
    blu_pkg::bus_op_t op;
    logic [15:0]      addr;
    logic [7:0]       wdata;
    blu_pkg::status_t st;
    logic [7:0]       a, b, c, d, e, h, l;
  } load_result_t;

  class byte_load_scoreboard;
    logic [7:0]        gpr [7];
    bit                read_pending;
    blu_pkg::reg_idx_t fill_target;
    load_result_t      due_results [$];
    int                mismatches;

    function new();
      foreach (gpr[i]) gpr[i] = 8'h00;
      read_pending = 1'b0;
      fill_target  = blu_pkg::IDX_B;
      mismatches   = 0;
    endfunction

    function blu_pkg::reg_idx_t reg_slot(input logic [2:0] code);
      return (code == blu_pkg::CODE_A) ? blu_pkg::IDX_A : code;
    endfunction

    function void note_word(input logic c, input logic [7:0] op,
                            input logic [15:0] imm, input logic [7:0] rd);
      load_result_t      r;
      logic [15:0]       hl, hl_next, bc, de;
      logic [2:0]        dst, src;
      bit                issue_read;
      blu_pkg::reg_idx_t tgt;
      hl = {gpr[blu_pkg::IDX_H], gpr[blu_pkg::IDX_L]};
      bc = {gpr[blu_pkg::IDX_B], gpr[blu_pkg::IDX_C]};
      de = {gpr[blu_pkg::IDX_D], gpr[blu_pkg::IDX_E]};
      hl_next = hl;
      dst = op[5:3];
      src = op[2:0];
      issue_read = 1'b0;
      tgt = blu_pkg::IDX_A;
      r.op = blu_pkg::BUS_NONE;
      r.addr = 16'h0000;
      r.wdata = 8'h00;
      r.st = blu_pkg::ST_DONE;
      if (c == blu_pkg::CMD_READ_RETURN) begin
        if (read_pending) begin
          gpr[fill_target] = rd;
          read_pending = 1'b0;
        end else begin
          r.st = blu_pkg::ST_OUT_ORDER;
        end
      end else if (read_pending) begin
        r.st = blu_pkg::ST_OUT_ORDER;
      end else if (op >= blu_pkg::OP_LD_GROUP_LO && op <= blu_pkg::OP_LD_GROUP_HI
                   && op != blu_pkg::OP_HALT) begin
        if (src == blu_pkg::CODE_MEM_HL) begin
          issue_read = 1'b1;
          r.addr = hl;
          tgt = reg_slot(dst);
        end else if (dst == blu_pkg::CODE_MEM_HL) begin
          r.op = blu_pkg::BUS_WR;
          r.addr = hl;
          r.wdata = gpr[reg_slot(src)];
        end else begin
          gpr[reg_slot(dst)] = gpr[reg_slot(src)];
        end
      end else if ((op & blu_pkg::OP_LD_IMM_MASK) == blu_pkg::OP_LD_IMM_BITS) begin
        if (dst == blu_pkg::CODE_MEM_HL) begin
          r.op = blu_pkg::BUS_WR;
          r.addr = hl;
          r.wdata = imm[7:0];
        end else begin
          gpr[reg_slot(dst)] = imm[7:0];
        end
      end else begin
        case (op)
          blu_pkg::OP_LD_BC_A: begin
            r.op = blu_pkg::BUS_WR; r.addr = bc; r.wdata = gpr[blu_pkg::IDX_A];
          end
          blu_pkg::OP_LD_DE_A: begin
            r.op = blu_pkg::BUS_WR; r.addr = de; r.wdata = gpr[blu_pkg::IDX_A];
          end
          blu_pkg::OP_LD_A_BC: begin
            issue_read = 1'b1; r.addr = bc;
          end
          blu_pkg::OP_LD_A_DE: begin
            issue_read = 1'b1; r.addr = de;
          end
          blu_pkg::OP_LD_HLI_A: begin
            r.op = blu_pkg::BUS_WR; r.addr = hl; r.wdata = gpr[blu_pkg::IDX_A];
            hl_next = hl + 16'd1;
          end
          blu_pkg::OP_LD_HLD_A: begin
            r.op = blu_pkg::BUS_WR; r.addr = hl; r.wdata = gpr[blu_pkg::IDX_A];
            hl_next = hl - 16'd1;
          end
          blu_pkg::OP_LD_A_HLI: begin
            issue_read = 1'b1; r.addr = hl; hl_next = hl + 16'd1;
          end
          blu_pkg::OP_LD_A_HLD: begin
            issue_read = 1'b1; r.addr = hl; hl_next = hl - 16'd1;
          end
          blu_pkg::OP_LDH_N_A: begin
            r.op = blu_pkg::BUS_WR;
            r.addr = blu_pkg::HIGH_PAGE | {8'h00, imm[7:0]};
            r.wdata = gpr[blu_pkg::IDX_A];
          end
          blu_pkg::OP_LDH_A_N: begin
            issue_read = 1'b1; r.addr = blu_pkg::HIGH_PAGE | {8'h00, imm[7:0]};
          end
          blu_pkg::OP_LDH_C_A: begin
            r.op = blu_pkg::BUS_WR;
            r.addr = blu_pkg::HIGH_PAGE | {8'h00, gpr[blu_pkg::IDX_C]};
            r.wdata = gpr[blu_pkg::IDX_A];
          end
          blu_pkg::OP_LDH_A_C: begin
            issue_read = 1'b1;
            r.addr = blu_pkg::HIGH_PAGE | {8'h00, gpr[blu_pkg::IDX_C]};
          end
          blu_pkg::OP_LD_NN_A: begin
            r.op = blu_pkg::BUS_WR; r.addr = imm; r.wdata = gpr[blu_pkg::IDX_A];
          end
          blu_pkg::OP_LD_A_NN: begin
            issue_read = 1'b1; r.addr = imm;
          end
          default: begin
            r.st = blu_pkg::ST_UNSUP;
          end
        endcase
        gpr[blu_pkg::IDX_H] = hl_next[15:8];
        gpr[blu_pkg::IDX_L] = hl_next[7:0];
      end
      if (issue_read) begin
        r.op = blu_pkg::BUS_RD;
        r.st = blu_pkg::ST_WAIT;
        read_pending = 1'b1;
        fill_target = tgt;
      end
      r.a = gpr[blu_pkg::IDX_A];
      r.b = gpr[blu_pkg::IDX_B];
      r.c = gpr[blu_pkg::IDX_C];
      r.d = gpr[blu_pkg::IDX_D];
      r.e = gpr[blu_pkg::IDX_E];
      r.h = gpr[blu_pkg::IDX_H];
      r.l = gpr[blu_pkg::IDX_L];
      due_results.push_back(r);
    endfunction

    function void compare_field(input string name, input logic [15:0] want,
                                input logic [15:0] got);
      if (got !== want) begin
        $display("%0t: %s expected %h, got %h", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(input load_result_t got);
      load_result_t want;
      if (due_results.size() == 0) begin
        $display("%0t: result word with none expected, bus_op %h addr %h status %h",
                 $time, got.op, got.addr, got.st);
        mismatches++;
        return;
      end
      want = due_results.pop_front();
      compare_field("bus_op", 16'(want.op), 16'(got.op));
      compare_field("bus_addr", want.addr, got.addr);
      compare_field("bus_wdata", 16'(want.wdata), 16'(got.wdata));
      compare_field("status", 16'(want.st), 16'(got.st));
      compare_field("value_a", 16'(want.a), 16'(got.a));
      compare_field("value_b", 16'(want.b), 16'(got.b));
      compare_field("value_c", 16'(want.c), 16'(got.c));
      compare_field("value_d", 16'(want.d), 16'(got.d));
      compare_field("value_e", 16'(want.e), 16'(got.e));
      compare_field("value_h", 16'(want.h), 16'(got.h));
      compare_field("value_l", 16'(want.l), 16'(got.l));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        cmd = 1'b0;
  logic [7:0]  opcode = 8'h00;
  logic [15:0] immediate = 16'h0000;
  logic [7:0]  read_data = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  bus_op;
  logic [15:0] bus_addr;
  logic [7:0]  bus_wdata;
  logic [1:0]  status;
  logic [7:0]  value_a, value_b, value_c, value_d, value_e, value_h, value_l;

  byte_load_scoreboard sb = new();
  bit hold_req = 1'b0;
  int burst_left = 0;
  int quiet_cycles = 0;

  byte_load_instruction_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .cmd(cmd), .opcode(opcode), .immediate(immediate), .read_data(read_data),
    .out_valid(out_valid), .out_ready(out_ready),
    .bus_op(bus_op), .bus_addr(bus_addr), .bus_wdata(bus_wdata), .status(status),
    .value_a(value_a), .value_b(value_b), .value_c(value_c), .value_d(value_d),
    .value_e(value_e), .value_h(value_h), .value_l(value_l)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [7:0] pick_opcode();
    int          r;
    logic [2:0]  dst;
    logic [7:0]  op;
    r = $urandom_range(0, 99);
    dst = 3'($urandom_range(0, 7));
    if (r < 40) begin
      op = 8'($urandom_range(blu_pkg::OP_LD_GROUP_LO, blu_pkg::OP_LD_GROUP_HI));
    end else if (r < 60) begin
      op = {2'b00, dst, 3'b110};
    end else if (r < 92) begin
      case ($urandom_range(0, 13))
        0: op = blu_pkg::OP_LD_BC_A;
        1: op = blu_pkg::OP_LD_DE_A;
        2: op = blu_pkg::OP_LD_A_BC;
        3: op = blu_pkg::OP_LD_A_DE;
        4: op = blu_pkg::OP_LD_HLI_A;
        5: op = blu_pkg::OP_LD_HLD_A;
        6: op = blu_pkg::OP_LD_A_HLI;
        7: op = blu_pkg::OP_LD_A_HLD;
        8: op = blu_pkg::OP_LDH_N_A;
        9: op = blu_pkg::OP_LDH_A_N;
        10: op = blu_pkg::OP_LDH_C_A;
        11: op = blu_pkg::OP_LDH_A_C;
        12: op = blu_pkg::OP_LD_NN_A;
        default: op = blu_pkg::OP_LD_A_NN;
      endcase
    end else begin
      op = 8'($urandom_range(0, 255));
    end
    return op;
  endfunction

  task automatic issue(input logic c, input logic [7:0] op, input logic [15:0] imm,
                       input logic [7:0] rd);
    int gap;
    if (burst_left > 0) begin
      burst_left--;
      gap = 0;
    end else begin
      gap = idle_len();
      if ($urandom_range(0, 49) == 0) burst_left = $urandom_range(20, 60);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= c;
    opcode <= op;
    immediate <= imm;
    read_data <= rd;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_word(c, op, imm, rd);
  endtask

  initial begin
    int run;
    int stall;
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        stall = idle_len();
        if (stall > 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
        run = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 100) : $urandom_range(1, 8);
        out_ready <= 1'b1;
        repeat (run) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : watch_results
    load_result_t got;
    if (!rst && out_valid && out_ready) begin
      got.op = blu_pkg::bus_op_t'(bus_op);
      got.addr = bus_addr;
      got.wdata = bus_wdata;
      got.st = blu_pkg::status_t'(status);
      got.a = value_a;
      got.b = value_b;
      got.c = value_c;
      got.d = value_d;
      got.e = value_e;
      got.h = value_h;
      got.l = value_l;
      sb.check_result(got);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    int         sent;
    logic       c;
    logic [7:0] op;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    issue(blu_pkg::CMD_READ_RETURN, 8'h00, 16'h0000, 8'hff);
    issue(blu_pkg::CMD_EXECUTE, OP_LD_A_N, 16'h12ff, 8'h00);
    issue(blu_pkg::CMD_EXECUTE, OP_LD_B_N, 16'hff80, 8'h00);
    issue(blu_pkg::CMD_EXECUTE, OP_LD_C_N, 16'h007f, 8'h00);
    issue(blu_pkg::CMD_EXECUTE, blu_pkg::OP_LD_BC_A, 16'h0000, 8'h00);
    issue(blu_pkg::CMD_EXECUTE, blu_pkg::OP_LDH_C_A, 16'h0000, 8'h00);
    issue(blu_pkg::CMD_EXECUTE, OP_LD_H_N, 16'h00ff, 8'h00);
    issue(blu_pkg::CMD_EXECUTE, OP_LD_L_N, 16'h00ff, 8'h00);
    issue(blu_pkg::CMD_EXECUTE, blu_pkg::OP_LD_HLI_A, 16'h0000, 8'h00);
    issue(blu_pkg::CMD_EXECUTE, blu_pkg::OP_LD_HLD_A, 16'h0000, 8'h00);
    issue(blu_pkg::CMD_EXECUTE, blu_pkg::OP_LD_A_HLI, 16'h0000, 8'h00);
    issue(blu_pkg::CMD_EXECUTE, OP_LD_A_B, 16'hffff, 8'hff);
    issue(blu_pkg::CMD_READ_RETURN, 8'h00, 16'h0000, 8'ha5);
    issue(blu_pkg::CMD_EXECUTE, blu_pkg::OP_HALT, 16'h0000, 8'h00);
    issue(blu_pkg::CMD_EXECUTE, OP_UNDEF, 16'h0000, 8'h00);
    issue(blu_pkg::CMD_EXECUTE, OP_LD_HL_B, 16'h0000, 8'h00);
    issue(blu_pkg::CMD_EXECUTE, OP_LD_HL_N, 16'hffc3, 8'h00);
    issue(blu_pkg::CMD_EXECUTE, blu_pkg::OP_LD_NN_A, 16'hffff, 8'h00);
    issue(blu_pkg::CMD_EXECUTE, blu_pkg::OP_LD_A_NN, 16'h0000, 8'h00);
    issue(blu_pkg::CMD_READ_RETURN, 8'h00, 16'h0000, 8'h3c);
    issue(blu_pkg::CMD_EXECUTE, blu_pkg::OP_LDH_A_N, 16'h00ff, 8'h00);
    issue(blu_pkg::CMD_READ_RETURN, 8'h00, 16'h0000, 8'h00);
    issue(blu_pkg::CMD_EXECUTE, OP_LD_A_HL, 16'h0000, 8'h00);
    issue(blu_pkg::CMD_READ_RETURN, 8'h00, 16'h0000, 8'h5a);
    issue(blu_pkg::CMD_EXECUTE, blu_pkg::OP_LDH_A_C, 16'h0000, 8'h00);
    issue(blu_pkg::CMD_READ_RETURN, 8'h00, 16'h0000, 8'hc3);

    sent = 0;
    while (sent < RANDOM_WORDS) begin
      if (sent == 200 || sent == 600) begin
        hold_req = 1'b1;
        burst_left = 40;
      end
      op = 8'($urandom_range(0, 255));
      if (sb.read_pending) begin
        if ($urandom_range(0, 99) < 88) begin
          c = blu_pkg::CMD_READ_RETURN;
        end else begin
          c = blu_pkg::CMD_EXECUTE;
        end
      end else if ($urandom_range(0, 99) < 6) begin
        c = blu_pkg::CMD_READ_RETURN;
      end else begin
        c = blu_pkg::CMD_EXECUTE;
        op = pick_opcode();
      end
      issue(c, op, 16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
      sent++;
    end
    in_valid <= 1'b0;

    while (sb.due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: byte_load_instruction_unit.f
rtl/core/blu_pkg.sv
rtl/core/blu_front.sv
rtl/core/blu_queue.sv
rtl/core/blu_execute.sv
rtl/core/byte_load_instruction_unit.sv
sim/tb_byte_load_instruction_unit.sv
